@@ hw/rtl/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg
// Types and codes used by the keyed count table.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int TYPE_W = 8;
   localparam int ID_W   = 20;
   localparam int KEY_W  = TYPE_W + ID_W;
   localparam int VAL_W  = 16;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 3;

   localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SET_OVR   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DECREMENT = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QRY_COUNT = 3'd4;
   localparam logic [ACT_W-1:0] ACT_QRY_OVR   = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RENAME    = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STAT_W-1:0] ST_COLLISION = 3'd4;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [TYPE_W-1:0] entity_type;
      logic [ID_W-1:0]   entity_id;
      logic [VAL_W-1:0]  override_value;
      logic              include_override;
      logic [ID_W-1:0]   new_id;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [VAL_W-1:0]  value_out;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] count;
      logic [VAL_W-1:0] override_limit;
   } entry_data_type;

endpackage

@@ hw/rtl/keyed_count_table.sv @@
// ----------------------------------------------------------------------------
// keyed_count_table
// Table of load counts and override limits keyed by entity type and id.
// Keys and valid bits sit in registers and are matched in parallel; count and
// override of each entry live in one RAM and are read, updated and written.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_data      taken when start high and busy low
//  response  rsp_valid, rsp_data        one-cycle strobe, no back pressure
//
//  Each item has a key match cycle that issues the RAM read, then an execute
//  cycle that writes any update back. busy is high in the match cycle only,
//  so a new transaction can be taken in the execute cycle of the last one.
//  The response appears the cycle after the execute cycle. Reset clears all
//  valid bits at once; the RAM needs no clearing. The receiver cannot stall.
// ----------------------------------------------------------------------------
module keyed_count_table
   import kct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int DAT_W = 2 * VAL_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]         key_ff [TABLE_ENTRIES];
   logic [KEY_W-1:0]         key_in [TABLE_ENTRIES];

   logic                     found_ff, free_ok_ff, new_hit_ff;
   logic [IDX_W-1:0]         match_idx_ff, free_idx_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [KEY_W-1:0]         lk_key, nw_key;
   logic [TABLE_ENTRIES-1:0] hit, nhit, freev, hit_low, free_low;
   logic [IDX_W-1:0]         match_idx, free_idx;

   logic                     accept;
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   entry_data_type           ram_wr_data, ram_rd_data;
   logic [VAL_W-1:0]         cnt_next;

   assign accept = start && !busy;
   assign busy   = (state_ff == S_LOOK);
   assign lk_key = {req_ff.entity_type, req_ff.entity_id};
   assign nw_key = {req_ff.entity_type, req_ff.new_id};

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit[i]   = valid_ff[i] && (key_ff[i] == lk_key);
         nhit[i]  = valid_ff[i] && (key_ff[i] == nw_key);
         freev[i] = !valid_ff[i];
      end
      hit_low  = hit & (~hit + TABLE_ENTRIES'(1));
      free_low = freev & (~freev + TABLE_ENTRIES'(1));
      match_idx = '0;
      free_idx  = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit_low[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
         if (free_low[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   kct_ram #(
      .WIDTH(DAT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == S_LOOK),
      .rd_addr (match_idx),
      .rd_data (ram_rd_data)
   );

   assign cnt_next = (ram_rd_data.count == VAL_MAX) ? ram_rd_data.count
                                                    : ram_rd_data.count + VAL_W'(1);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      key_in       = key_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = match_idx_ff;
      ram_wr_data  = ram_rd_data;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in         = accept ? S_LOOK : S_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_in.found     = found_ff;
            rsp_in.value_out = '0;
            rsp_in.status    = ST_OK;
            case (req_ff.action)
               ACT_ADD: begin
                  if (found_ff) begin
                     ram_wr_en         = 1'b1;
                     ram_wr_data.count = cnt_next;
                     if (ram_rd_data.override_limit != '0 &&
                         cnt_next > ram_rd_data.override_limit) begin
                        ram_wr_data.override_limit = cnt_next;
                     end
                  end else if (free_ok_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_data           = '{count: VAL_W'(1), override_limit: '0};
                     valid_in[free_idx_ff] = 1'b1;
                     key_in[free_idx_ff]   = lk_key;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               ACT_SET_OVR: begin
                  if (found_ff) begin
                     ram_wr_en                  = 1'b1;
                     ram_wr_data.override_limit = req_ff.override_value;
                  end else if (free_ok_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_data           = '{count: '0,
                                               override_limit: req_ff.override_value};
                     valid_in[free_idx_ff] = 1'b1;
                     key_in[free_idx_ff]   = lk_key;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               ACT_DECREMENT: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else if (ram_rd_data.count == '0) begin
                     rsp_in.status = ST_UNDERFLOW;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_data.count = ram_rd_data.count - VAL_W'(1);
                     if (ram_rd_data.count == VAL_W'(1)) begin
                        valid_in[match_idx_ff] = 1'b0;
                     end
                  end
               end
               ACT_DELETE: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     valid_in[match_idx_ff] = 1'b0;
                  end
               end
               ACT_QRY_COUNT: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else if (req_ff.include_override &&
                               ram_rd_data.override_limit != '0) begin
                     rsp_in.value_out = ram_rd_data.override_limit;
                  end else begin
                     rsp_in.value_out = ram_rd_data.count;
                  end
               end
               ACT_QRY_OVR: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     rsp_in.value_out = ram_rd_data.override_limit;
                  end
               end
               ACT_RENAME: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else if (nw_key != lk_key && new_hit_ff) begin
                     rsp_in.status = ST_COLLISION;
                  end else begin
                     key_in[match_idx_ff] = nw_key;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_LOOK) begin
         found_ff     <= |hit;
         free_ok_ff   <= |freev;
         new_hit_ff   <= |nhit;
         match_idx_ff <= match_idx;
         free_idx_ff  <= free_idx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_exec : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("response without execute cycle");

   a_accept_to_look : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOK))
      else $error("accepted transaction did not enter match cycle");

   a_write_has_slot : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == S_EXEC) && (found_ff || free_ok_ff)))
      else $error("RAM write without a matched or free entry");

   a_collision_found : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_COLLISION) |-> rsp_ff.found)
      else $error("collision reported for a missing key");

   a_one_hit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |-> $onehot0(hit))
      else $error("duplicate keys in table");
`endif

endmodule

@@ hw/rtl/kct_ram.sv @@
// ----------------------------------------------------------------------------
// kct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
